[design/csk_pkg.sv]
// Shared constants, operation codes and controller/datapath structs
// for the count sketch block. No dependencies.
package csk_pkg;

  localparam int ROWS_DEF    = 4;
  localparam int COLUMNS_DEF = 1024;

  localparam logic [31:0] MM_MUL = 32'h5bd1_e995;

  // datapath operations issued by the controller
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_CLR  = 4'd1;
  localparam logic [3:0] OP_LOAD = 4'd2;
  localparam logic [3:0] OP_INIT = 4'd3;
  localparam logic [3:0] OP_K1   = 4'd4;
  localparam logic [3:0] OP_K2   = 4'd5;
  localparam logic [3:0] OP_HM   = 4'd6;
  localparam logic [3:0] OP_TAIL = 4'd7;
  localparam logic [3:0] OP_F1   = 4'd8;
  localparam logic [3:0] OP_F2   = 4'd9;
  localparam logic [3:0] OP_MOD  = 4'd10;
  localparam logic [3:0] OP_RD   = 4'd11;
  localparam logic [3:0] OP_UPD  = 4'd12;
  localparam logic [3:0] OP_OUT  = 4'd13;

  typedef struct packed {
    logic [3:0] op;
  } csk_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic any_block;
    logic more_blocks;
    logic has_tail;
    logic mod_last;
    logic last_row;
  } csk_status_t;

endpackage

[design/count_sketch_update_query.sv]
// Top level of the count sketch: insert and median query over ROWS hashed rows.
// Depends on csk_pkg, csk_ctrl and csk_datapath.
//
//   channel   handshake             payload
//   request   req_valid/req_ready   kind, key, key_len, increment
//   result    est_valid/est_ready   estimate
//
// One request at a time. Per row, each whole 4-byte key word (0..2 of them) passes
// the single shared hash multiplier in states K1, K2 and HM, a partial word in TAIL;
// the three-step column reduction follows. These set the time from acceptance to
// the result being offered. req_ready rises in the cycle after the result is taken.
// After reset a clearing pass zeroes the counter memory, with req_ready low.
// A stalled result holds in its register until taken.
module count_sketch_update_query
  import csk_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               kind,
  input  logic [63:0]        key,
  input  logic [3:0]         key_len,
  input  logic signed [31:0] increment,
  output logic               est_valid,
  input  logic               est_ready,
  output logic signed [31:0] estimate
);

  csk_cmd_t    cmd;
  csk_status_t status;

  // sequence the hash, reduction, memory access and output hand-off
  csk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .est_valid (est_valid),
    .est_ready (est_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // hold the request, hash each row, update or collect counters
  csk_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .kind      (kind),
    .key       (key),
    .key_len   (key_len),
    .increment (increment),
    .estimate  (estimate)
  );

endmodule

[design/csk_ctrl.sv]
// Sequencing state machine for the count sketch block.
// Depends on csk_pkg for operation codes and the command/status structs.
module csk_ctrl
  import csk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  output logic        est_valid,
  input  logic        est_ready,
  input  csk_status_t status,
  output csk_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_K1    = 4'd3;
  localparam logic [3:0] S_K2    = 4'd4;
  localparam logic [3:0] S_HM    = 4'd5;
  localparam logic [3:0] S_TAIL  = 4'd6;
  localparam logic [3:0] S_F1    = 4'd7;
  localparam logic [3:0] S_F2    = 4'd8;
  localparam logic [3:0] S_MOD   = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_UPD   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUTW  = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    req_ready  = 1'b0;
    est_valid  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (status.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        if (status.any_block)     state_next = S_K1;
        else if (status.has_tail) state_next = S_TAIL;
        else                      state_next = S_F1;
      end
      S_K1: begin
        cmd.op     = OP_K1;
        state_next = S_K2;
      end
      S_K2: begin
        cmd.op     = OP_K2;
        state_next = S_HM;
      end
      S_HM: begin
        cmd.op = OP_HM;
        if (status.more_blocks)   state_next = S_K1;
        else if (status.has_tail) state_next = S_TAIL;
        else                      state_next = S_F1;
      end
      S_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = S_F1;
      end
      S_F1: begin
        cmd.op     = OP_F1;
        state_next = S_F2;
      end
      S_F2: begin
        cmd.op     = OP_F2;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (status.mod_last) state_next = S_RD;
      end
      S_RD: begin
        cmd.op     = OP_RD;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = status.last_row ? S_FIN : S_INIT;
      end
      S_FIN: begin
        cmd.op     = OP_OUT;
        state_next = S_OUTW;
      end
      S_OUTW: begin
        est_valid = 1'b1;
        if (est_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[design/csk_datapath.sv]
// Hash, column reduction, counter memory and median sort for the count sketch.
// Depends on csk_pkg for the hash multiplier, operation codes and structs.
module csk_datapath
  import csk_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  csk_cmd_t           cmd,
  output csk_status_t        status,
  input  logic               kind,
  input  logic [63:0]        key,
  input  logic [3:0]         key_len,
  input  logic signed [31:0] increment,
  output logic signed [31:0] estimate
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [31:0] COLS_W = 32'(COLUMNS);
  // floor(2^32 / COLUMNS): the quotient estimate falls short by at most one
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(COLUMNS));

  logic signed [31:0] mem [DEPTH];

  logic               kind_q;
  logic [63:0]        key_q;
  logic [3:0]         len_q;
  logic signed [31:0] inc_q;
  logic [31:0]        h, k;
  logic               blk;
  logic [1:0]         nblocks;
  logic [CW-1:0]      rem;
  logic [1:0]         mod_step;
  logic [RW-1:0]      row;
  logic [AW-1:0]      base, clr_addr, addr;
  logic               plus;
  logic signed [31:0] rdata;
  logic signed [31:0] srt [ROWS];

  logic [31:0]        mul_in, product, tail_word;
  logic [63:0]        recip_prod;
  logic [31:0]        quot, part;
  logic signed [31:0] val, delta;
  logic [ROWS-1:0]    lt;
  logic [3:0]         len_sat;

  assign len_sat = (key_len > 4'd8) ? 4'd8 : key_len;
  assign nblocks = (len_q == 4'd8) ? 2'd2 : ((len_q >= 4'd4) ? 2'd1 : 2'd0);
  assign addr    = base + AW'(rem);

  always_comb begin
    tail_word = (nblocks == 2'd1) ? key_q[63:32] : key_q[31:0];
    unique case (len_q[1:0])
      2'd1:    tail_word = tail_word & 32'h0000_00ff;
      2'd2:    tail_word = tail_word & 32'h0000_ffff;
      2'd3:    tail_word = tail_word & 32'h00ff_ffff;
      default: tail_word = 32'd0;
    endcase
  end

  // one shared multiplier by the hash constant
  always_comb begin
    unique case (cmd.op)
      OP_K1:   mul_in = blk ? key_q[63:32] : key_q[31:0];
      OP_K2:   mul_in = k ^ (k >> 24);
      OP_TAIL: mul_in = h ^ tail_word;
      OP_F1:   mul_in = h ^ (h >> 13);
      default: mul_in = h;
    endcase
  end
  assign product = mul_in * MM_MUL;

  // column reduction by reciprocal multiplication, then one correcting subtract
  assign recip_prod = 64'(h) * 64'(RECIP);

  assign delta = plus ? inc_q : -inc_q;
  assign val   = plus ? rdata : -rdata;

  // insertion into the sorted list: entries at or beyond the fill count act as +inf
  always_comb begin
    for (int i = 0; i < ROWS; i++) begin
      lt[i] = (i >= int'(row)) || (val < srt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR) begin
      mem[clr_addr] <= '0;
    end else if (cmd.op == OP_UPD && !kind_q) begin
      mem[addr] <= rdata + delta;
    end
    if (cmd.op == OP_RD) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_q <= kind;
        key_q  <= key;
        len_q  <= len_sat;
        inc_q  <= increment;
        row    <= '0;
        base   <= '0;
        blk    <= 1'b0;
      end
      OP_INIT: h <= 32'(row) ^ 32'(len_q);
      OP_K1:   k <= product;
      OP_K2:   k <= product;
      OP_HM: begin
        h   <= product ^ k;
        blk <= ~blk;
      end
      OP_TAIL: h <= product;
      OP_F1:   h <= product;
      OP_F2: begin
        h        <= h ^ (h >> 15);
        plus     <= h[31];
        mod_step <= '0;
      end
      OP_MOD: begin
        unique case (mod_step)
          2'd0:    quot <= recip_prod[63:32];
          2'd1:    part <= h - quot * COLS_W;
          default: rem  <= CW'((part >= COLS_W) ? part - COLS_W : part);
        endcase
        mod_step <= mod_step + 1'b1;
      end
      OP_UPD: begin
        if (kind_q) begin
          for (int i = 0; i < ROWS; i++) begin
            if (lt[i]) srt[i] <= (i > 0 && lt[(i > 0) ? i-1 : 0]) ? srt[(i > 0) ? i-1 : 0]
                                                                   : val;
          end
        end
        row  <= row + 1'b1;
        base <= base + AW'(COLUMNS);
        blk  <= 1'b0;
      end
      OP_OUT:  estimate <= kind_q ? srt[ROWS/2] : 32'sd0;
      default: ;
    endcase
  end

  assign status.clear_done  = (clr_addr == AW'(DEPTH - 1));
  assign status.any_block   = (nblocks != 2'd0);
  assign status.more_blocks = !blk && (nblocks == 2'd2);
  assign status.has_tail    = (len_q[1:0] != 2'd0);
  assign status.mod_last    = (mod_step == 2'd2);
  assign status.last_row    = (row == RW'(ROWS - 1));

endmodule

[sim/count_sketch_update_query_tb.sv]
// Self-checking testbench for count_sketch_update_query: insert and median query requests.
// Depends on csk_pkg and the count_sketch_update_query RTL; predicts every estimate itself.
`timescale 1ns / 100ps

module count_sketch_update_query_tb;
  import csk_pkg::*;

  localparam int NROW = ROWS_DEF;
  localparam int NCOL = COLUMNS_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        kind;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] increment;
    bit          hold;     // wait until every estimate is back before offering
  } sketch_req_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic               kind;
  logic [63:0]        key;
  logic [3:0]         key_len;
  logic signed [31:0] increment;
  logic               est_valid;
  logic               est_ready;
  logic signed [31:0] estimate;

  count_sketch_update_query uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .kind(kind), .key(key), .key_len(key_len), .increment(increment),
    .est_valid(est_valid), .est_ready(est_ready), .estimate(estimate)
  );

  sketch_req_t pending_reqs[$];
  logic [31:0] estimates_due[$];
  logic [31:0] sketch_counters[NROW*NCOL];
  int          errors = 0;
  int          n_inserts = 0;
  int          n_queries = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          cycles = 0;
  bit          quiet_send = 0;
  bit          quiet_recv = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; quiet stretches give none at all.
  function automatic int pick_gap(bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 60);
  endfunction

  // MurmurHash2 over the first n key bytes, little-endian.
  function automatic logic [31:0] murmur_hash(logic [63:0] k, int unsigned n, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] w;
    int unsigned pos;
    int unsigned rem;
    h = seed ^ n;
    pos = 0;
    while (n - pos >= 4) begin
      w = k[pos*8 +: 32];
      w = w * MM_MUL;
      w = w ^ (w >> 24);
      w = w * MM_MUL;
      h = h * MM_MUL;
      h = h ^ w;
      pos += 4;
    end
    rem = n - pos;
    if (rem == 3) h = h ^ ({24'd0, k[(pos+2)*8 +: 8]} << 16);
    if (rem >= 2) h = h ^ ({24'd0, k[(pos+1)*8 +: 8]} << 8);
    if (rem >= 1) begin
      h = h ^ {24'd0, k[pos*8 +: 8]};
      h = h * MM_MUL;
    end
    h = h ^ (h >> 13);
    h = h * MM_MUL;
    h = h ^ (h >> 15);
    return h;
  endfunction

  // Apply one request to the shadow counters and return the estimate it yields.
  function automatic logic [31:0] sketch_estimate(sketch_req_t rq);
    logic signed [31:0] vals[NROW];
    logic signed [31:0] t;
    logic [31:0] h;
    int unsigned n;
    int idx;
    n = (rq.key_len > 8) ? 8 : rq.key_len;
    for (int r = 0; r < NROW; r++) begin
      h = murmur_hash(rq.key, n, r);
      idx = r * NCOL + int'(h % NCOL);
      if (rq.kind == 1'b0)
        sketch_counters[idx] = h[31] ? sketch_counters[idx] + rq.increment
                                     : sketch_counters[idx] - rq.increment;
      else
        vals[r] = h[31] ? sketch_counters[idx] : 32'd0 - sketch_counters[idx];
    end
    if (rq.kind == 1'b0) return 32'd0;
    for (int i = 0; i < NROW; i++)
      for (int j = 0; j < NROW - 1 - i; j++)
        if (vals[j+1] < vals[j]) begin
          t = vals[j]; vals[j] = vals[j+1]; vals[j+1] = t;
        end
    return vals[NROW/2];
  endfunction

  // Driver: offer the next pending request, hold it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        estimates_due.push_back(sketch_estimate(pending_reqs.pop_front()));
        send_gap = pick_gap(quiet_send);
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     (!pending_reqs[0].hold || estimates_due.size() == 0)) begin
          req_valid <= 1'b1;
          kind      <= pending_reqs[0].kind;
          key       <= pending_reqs[0].key;
          key_len   <= pending_reqs[0].key_len;
          increment <= pending_reqs[0].increment;
          if (pending_reqs[0].kind) n_queries++; else n_inserts++;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each estimate taken against the oldest one due, then stall at random.
  always @(posedge clk) begin
    if (rst) begin
      est_ready <= 1'b0;
    end else begin
      if (est_valid && est_ready) begin
        if (estimates_due.size() == 0) begin
          $display("%0t: estimate %0d with nothing expected", $time, estimate);
          errors++;
        end else begin
          if (estimate !== estimates_due[0]) begin
            $display("%0t: estimate mismatch, expected %0d actual %0d",
                     $time, $signed(estimates_due[0]), estimate);
            errors++;
          end
          void'(estimates_due.pop_front());
        end
        recv_gap = pick_gap(quiet_recv);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        est_ready <= 1'b0;
      end else begin
        est_ready <= 1'b1;
      end
    end
  end

  // Watchdog: covers the clearing pass and the slowest path with stalls, several times over.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic sketch_req_t mk_req(logic k, logic [63:0] ky, logic [3:0] n,
                                         logic [31:0] inc, bit hold);
    sketch_req_t rq;
    rq.kind = k; rq.key = ky; rq.key_len = n; rq.increment = inc; rq.hold = hold;
    return rq;
  endfunction

  logic [63:0] key_pool[16];
  logic [3:0]  len_pool[16];

  initial begin
    int p;
    logic [31:0] inc;
    logic [3:0] n;
    rst = 1'b1;
    req_valid = 1'b0;
    est_ready = 1'b0;
    kind = 1'b0;
    key = '0;
    key_len = 4'd1;
    increment = '0;
    for (int i = 0; i < NROW*NCOL; i++) sketch_counters[i] = 32'd0;

    // directed: length extremes, key extremes, wrap-around, most negative value
    pending_reqs.push_back(mk_req(1'b1, 64'h0, 4'd1, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, {64{1'b1}}, 4'd8, 32'h7fffffff, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, {64{1'b1}}, 4'd8, 32'h7fffffff, 1'b0));
    pending_reqs.push_back(mk_req(1'b1, {64{1'b1}}, 4'd8, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, 64'h5a, 4'd1, 32'h80000000, 1'b0));
    pending_reqs.push_back(mk_req(1'b1, 64'h5a, 4'd1, 32'h7fffffff, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, 64'h0, 4'd0, 32'd17, 1'b0));        // empty key
    pending_reqs.push_back(mk_req(1'b1, 64'hffff, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, 64'h0123456789abcdef, 4'd15, 32'hffffffff, 1'b0));
    pending_reqs.push_back(mk_req(1'b1, 64'h0123456789abcdef, 4'd9, 32'd0, 1'b0)); // saturated
    pending_reqs.push_back(mk_req(1'b1, 64'h0123456789abcdef, 4'd8, 32'd0, 1'b0));
    pending_reqs.push_back(mk_req(1'b0, 64'hdeadbeef_00112233, 4'd3, 32'd1000, 1'b0));
    pending_reqs.push_back(mk_req(1'b1, 64'h12345678_ff112233, 4'd3, 32'd0, 1'b1)); // upper bytes
    for (int l = 2; l <= 7; l++) begin
      pending_reqs.push_back(mk_req(1'b0, 64'hf0e1d2c3b4a59687, 4'(l), 32'd5 * l, 1'b0));
      pending_reqs.push_back(mk_req(1'b1, 64'hf0e1d2c3b4a59687, 4'(l), 32'd0, 1'b0));
    end

    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      len_pool[i] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8));
    end
    // random: mostly a small pool of keys so queries see real counts, the rest noise
    for (int i = 0; i < 1425; i++) begin
      case ($urandom_range(0, 3))
        0: inc = $urandom;
        1: inc = 32'($signed($urandom_range(0, 40)) - 20);
        2: inc = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        default: inc = $urandom_range(0, 1000);
      endcase
      if ($urandom_range(0, 9) < 7) begin
        p = $urandom_range(0, 15);
        pending_reqs.push_back(mk_req(1'($urandom_range(0, 1)), key_pool[p], len_pool[p], inc,
                                      i % 300 == 299));
      end else begin
        n = 4'($urandom);
        pending_reqs.push_back(mk_req(1'($urandom_range(0, 1)), {$urandom, $urandom}, n, inc,
                                      i % 300 == 299));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // alternate stretches with and without idling
    while (pending_reqs.size() > 0 || req_valid) begin
      repeat (500) @(posedge clk);
      quiet_send = ($urandom_range(0, 3) == 0);
      quiet_recv = ($urandom_range(0, 3) == 0);
    end
    while (estimates_due.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d inserts and %0d queries, key lengths 0 to 15, wrap cases",
             n_inserts, n_queries);
    if (errors == 0 && estimates_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
